### rtl/qfgf_pkg.sv
// Package for the quad face geometric factor pipeline: shared types, constants and helpers.
package qfgf_pkg;

  // Chain layout: square-root cells first, the reciprocal runs beside them,
  // then the normal division cells.
  localparam int SQRT_STEPS = 32;
  localparam int IJ_STEPS = 31;
  localparam int NRM_STEPS = 16;
  localparam int NRM_FIRST = SQRT_STEPS;
  localparam int CHAIN_LEN = NRM_FIRST + NRM_STEPS;

  // Reciprocal of the Jacobian: dividend 2^48, and a magnitude up to 2^17
  // gives a quotient of 2^31 or more, which always saturates.
  localparam logic [48:0] IJ_DIVIDEND = 49'h1_0000_0000_0000;
  localparam logic [63:0] IJ_SAT_MAG = 64'd131072;

  // Payload that travels down the chain of cells.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic halved;
    logic [15:0] weight;
    logic [63:0] sq_rem;
    logic [31:0] root;
    logic [46:0] nx_rem;
    logic [46:0] ny_rem;
    logic [15:0] nx_q;
    logic [15:0] ny_q;
    logic j_neg;
    logic [63:0] j_mag;
    logic [48:0] ij_rem;
    logic [30:0] ij_q;
  } qfgf_item_t;

  // Rounded Q16.16 Jacobian entry, saturated to +-(2^31-1).
  function automatic logic signed [31:0] jac_entry(input logic signed [32:0] da,
                                                  input logic signed [32:0] db,
                                                  input logic signed [15:0] t);
    logic signed [17:0] one_m;
    logic signed [17:0] one_p;
    logic signed [52:0] sum;
    logic signed [52:0] q;
    one_m = 18'sd16384 - 18'(t);
    one_p = 18'sd16384 + 18'(t);
    sum = 53'(da) * 53'(one_m) + 53'(db) * 53'(one_p) + 53'sd32768;
    q = sum >>> 16;
    if (q > 53'sd2147483647) jac_entry = 32'sd2147483647;
    else if (q < -53'sd2147483647) jac_entry = -32'sd2147483647;
    else jac_entry = q[31:0];
  endfunction

endpackage

### rtl/quad_face_geometric_factors.sv
// Top level of the quad face geometric factor pipeline.
// One face node request enters per cycle and one result leaves per cycle when the output does not
// stall. A request passes through three entry stages (Jacobian entries and edge, determinant, its
// magnitude), a chain of 48 cells (32 square-root cells with the 31-bit reciprocal division
// running beside them, then 16 cells for the two normal divisions), a finishing stage and the
// output register. While a result waits under out_stall the whole pipeline holds and in_stall
// follows in the same cycle, so nothing is lost.
module quad_face_geometric_factors (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_vx0,
  input  logic signed [31:0] in_vx1,
  input  logic signed [31:0] in_vx2,
  input  logic signed [31:0] in_vx3,
  input  logic signed [31:0] in_vy0,
  input  logic signed [31:0] in_vy1,
  input  logic signed [31:0] in_vy2,
  input  logic signed [31:0] in_vy3,
  input  logic signed [15:0] in_ref_r,
  input  logic signed [15:0] in_ref_s,
  input  logic [1:0]         in_face_index,
  input  logic [15:0]        in_quad_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y,
  output logic [30:0]        out_surface_jacobian,
  output logic signed [31:0] out_inverse_jacobian,
  output logic [30:0]        out_weighted_surface_jacobian,
  output logic signed [31:0] out_inverse_size,
  output logic               out_degenerate
);

  localparam int NC = qfgf_pkg::CHAIN_LEN;

  logic stall;
  logic signed [31:0] xr_nxt, xs_nxt, yr_nxt, ys_nxt;
  logic signed [31:0] xr_r, xs_r, yr_r, ys_r;
  qfgf_pkg::qfgf_item_t s0_nxt, s0_r, s1_r, s2_nxt, s2_r;
  logic s0_v_r, s1_v_r, s2_v_r;
  logic signed [64:0] jdet_nxt, jdet_r;
  qfgf_pkg::qfgf_item_t ch_item [NC+1];
  logic ch_v [NC+1];
  qfgf_pkg::qfgf_item_t fin;
  logic f_v_r;
  logic [31:0] half_nxt, half_r;
  logic [15:0] nxq_nxt, nxq_r, nyq_nxt, nyq_r;
  logic [31:0] ijmag_nxt, ijmag_r;
  logic ijneg_nxt, ijneg_r;
  logic deg_nxt, deg_r;
  logic neg_x_r, neg_y_r;
  logic [15:0] weight_r;
  logic [47:0] wsj_full;
  logic [63:0] pm_full;
  logic [30:0] sj_nxt, wsj_nxt;
  logic [31:0] ij_nxt, isz_nxt;
  logic [15:0] nx_nxt, ny_nxt;

  assign stall = out_valid & out_stall;
  assign in_stall = stall;

  // Entry stage: Jacobian entries, edge vector and square-root operand.
  always_comb begin
    logic signed [32:0] xf, xg, yf, yg, nx, ny;
    logic [32:0] a, b;
    logic k;
    s0_nxt = '0;
    xr_nxt = qfgf_pkg::jac_entry(33'(in_vx1) - 33'(in_vx0), 33'(in_vx2) - 33'(in_vx3),
                                 in_ref_s);
    xs_nxt = qfgf_pkg::jac_entry(33'(in_vx3) - 33'(in_vx0), 33'(in_vx2) - 33'(in_vx1),
                                 in_ref_r);
    yr_nxt = qfgf_pkg::jac_entry(33'(in_vy1) - 33'(in_vy0), 33'(in_vy2) - 33'(in_vy3),
                                 in_ref_s);
    ys_nxt = qfgf_pkg::jac_entry(33'(in_vy3) - 33'(in_vy0), 33'(in_vy2) - 33'(in_vy1),
                                 in_ref_r);
    case (in_face_index)
      2'd0: begin xf = 33'(in_vx0); xg = 33'(in_vx1); yf = 33'(in_vy0); yg = 33'(in_vy1); end
      2'd1: begin xf = 33'(in_vx1); xg = 33'(in_vx2); yf = 33'(in_vy1); yg = 33'(in_vy2); end
      2'd2: begin xf = 33'(in_vx2); xg = 33'(in_vx3); yf = 33'(in_vy2); yg = 33'(in_vy3); end
      default: begin
        xf = 33'(in_vx3); xg = 33'(in_vx0); yf = 33'(in_vy3); yg = 33'(in_vy0);
      end
    endcase
    nx = yg - yf;
    ny = xf - xg;
    a = nx[32] ? 33'(-nx) : 33'(nx);
    b = ny[32] ? 33'(-ny) : 33'(ny);
    k = a[32] | a[31] | b[32] | b[31];
    if (k) begin a = a >> 1; b = b >> 1; end
    s0_nxt.neg_x = nx[32];
    s0_nxt.neg_y = ny[32];
    s0_nxt.halved = k;
    s0_nxt.weight = in_quad_weight;
    s0_nxt.sq_rem = 64'(a[31:0]) * 64'(a[31:0]) + 64'(b[31:0]) * 64'(b[31:0]);
    // The normal divisions give twice the quotient and round it at the end.
    s0_nxt.nx_rem = {a[31:0], 15'd0};
    s0_nxt.ny_rem = {b[31:0], 15'd0};
    s0_nxt.ij_rem = qfgf_pkg::IJ_DIVIDEND;
  end

  // Determinant, then its magnitude and sign.
  assign jdet_nxt = 65'(xr_r) * 65'(ys_r) - 65'(xs_r) * 65'(yr_r);

  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.j_neg = jdet_r[64];
    s2_nxt.j_mag = jdet_r[64] ? 64'(-jdet_r) : jdet_r[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (!stall) begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
    if (!stall) begin
      xr_r <= xr_nxt;
      xs_r <= xs_nxt;
      yr_r <= yr_nxt;
      ys_r <= ys_nxt;
      s0_r <= s0_nxt;
      s1_r <= s0_r;
      jdet_r <= jdet_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign ch_item[0] = s2_r;
  assign ch_v[0] = s2_v_r;

  // Chain of cells for the square root and the divisions.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    qfgf_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .stall(stall),
      .in_valid(ch_v[i]), .in_item(ch_item[i]),
      .out_valid(ch_v[i+1]), .out_item(ch_item[i+1])
    );
  end

  assign fin = ch_item[NC];

  // Finishing stage: half length, rounded normals, reciprocal saturation and the degenerate flag.
  always_comb begin
    logic j_zero;
    logic j_sat;
    j_zero = (fin.j_mag == 64'd0);
    j_sat = (fin.j_mag <= qfgf_pkg::IJ_SAT_MAG);
    half_nxt = fin.halved ? fin.root : {1'b0, fin.root[31:1]};
    if (fin.root == 32'd0) begin
      nxq_nxt = 16'd0;
      nyq_nxt = 16'd0;
    end else begin
      nxq_nxt = 16'((17'(fin.nx_q) + 17'd1) >> 1);
      nyq_nxt = 16'((17'(fin.ny_q) + 17'd1) >> 1);
    end
    if (j_zero) begin
      ijneg_nxt = 1'b0;
      ijmag_nxt = 32'h7FFF_FFFF;
    end else if (j_sat) begin
      ijneg_nxt = fin.j_neg;
      ijmag_nxt = fin.j_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      ijneg_nxt = fin.j_neg;
      ijmag_nxt = {1'b0, fin.ij_q};
    end
    deg_nxt = (fin.root == 32'd0) || j_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (!stall) f_v_r <= ch_v[NC];
    if (!stall) begin
      half_r <= half_nxt;
      nxq_r <= nxq_nxt;
      nyq_r <= nyq_nxt;
      ijmag_r <= ijmag_nxt;
      ijneg_r <= ijneg_nxt;
      deg_r <= deg_nxt;
      neg_x_r <= fin.neg_x;
      neg_y_r <= fin.neg_y;
      weight_r <= fin.weight;
    end
  end

  // Output values: signs, products and saturation.
  always_comb begin
    wsj_full = 48'(half_r) * 48'(weight_r);
    pm_full = 64'(half_r) * 64'(ijmag_r);
    sj_nxt = half_r[31] ? 31'h7FFF_FFFF : half_r[30:0];
    wsj_nxt = (wsj_full[47:45] != 3'd0) ? 31'h7FFF_FFFF : wsj_full[44:14];
    ij_nxt = ijneg_r ? -ijmag_r : ijmag_r;
    if (!ijneg_r) isz_nxt = (pm_full[63:47] != 17'd0) ? 32'h7FFF_FFFF : {1'b0, pm_full[46:16]};
    else isz_nxt = (pm_full[63:47] != 17'd0) ? 32'h8000_0000 : -{1'b0, pm_full[46:16]};
    nx_nxt = neg_x_r ? -nxq_r : nxq_r;
    ny_nxt = neg_y_r ? -nyq_r : nyq_r;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (!stall) out_valid <= f_v_r;
    if (!stall) begin
      out_normal_x <= nx_nxt;
      out_normal_y <= ny_nxt;
      out_surface_jacobian <= sj_nxt;
      out_inverse_jacobian <= ij_nxt;
      out_weighted_surface_jacobian <= wsj_nxt;
      out_inverse_size <= isz_nxt;
      out_degenerate <= deg_r;
    end
  end

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse_jacobian))
    else $error("result changed while stalled");
  // A zero half length gives a zero weighted surface Jacobian.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_surface_jacobian == 0 |-> out_weighted_surface_jacobian == 0)
    else $error("nonzero weighted surface Jacobian on zero half length");
  // A zero normal only comes from a zero edge, which is degenerate.
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_normal_x == 0 && out_normal_y == 0 |-> out_degenerate)
    else $error("degenerate flag missing");

endmodule

### rtl/qfgf_cell.sv
// One cell of the chain: a square-root bit and a reciprocal quotient bit, or normal quotient bits, as its step gives.
module qfgf_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 stall,
  input  logic                 in_valid,
  input  qfgf_pkg::qfgf_item_t in_item,
  output logic                 out_valid,
  output qfgf_pkg::qfgf_item_t out_item
);

  localparam int SQ_SH = (STEP < qfgf_pkg::SQRT_STEPS) ?
                         2 * (qfgf_pkg::SQRT_STEPS - 1 - STEP) : 0;
  localparam int IJ_SH = (STEP < qfgf_pkg::IJ_STEPS) ? qfgf_pkg::IJ_STEPS - 1 - STEP : 0;
  localparam int NRM_SH = (STEP >= qfgf_pkg::NRM_FIRST && STEP < qfgf_pkg::CHAIN_LEN) ?
                          qfgf_pkg::CHAIN_LEN - 1 - STEP : 0;

  qfgf_pkg::qfgf_item_t item_nxt;
  qfgf_pkg::qfgf_item_t item_r;
  logic valid_r;

  // Restoring square root, reciprocal long division and normal long division steps.
  always_comb begin
    logic [63:0] sq_top;
    logic [65:0] sq_trial;
    logic [48:0] ij_top;
    logic [46:0] nx_top;
    logic [46:0] ny_top;
    item_nxt = in_item;
    sq_top = in_item.sq_rem >> SQ_SH;
    sq_trial = {32'd0, in_item.root, 2'b01};
    ij_top = in_item.ij_rem >> IJ_SH;
    nx_top = in_item.nx_rem >> NRM_SH;
    ny_top = in_item.ny_rem >> NRM_SH;
    // One root bit.
    if (STEP < qfgf_pkg::SQRT_STEPS) begin
      if ({2'b00, sq_top} >= sq_trial) begin
        item_nxt.sq_rem = in_item.sq_rem - (sq_trial[63:0] << SQ_SH);
        item_nxt.root = {in_item.root[30:0], 1'b1};
      end else begin
        item_nxt.root = {in_item.root[30:0], 1'b0};
      end
    end
    // One bit of 2^48 over the Jacobian magnitude.
    if (STEP < qfgf_pkg::IJ_STEPS) begin
      if (64'(ij_top) >= in_item.j_mag) begin
        item_nxt.ij_rem = in_item.ij_rem - (in_item.j_mag[48:0] << IJ_SH);
        item_nxt.ij_q = {in_item.ij_q[29:0], 1'b1};
      end else begin
        item_nxt.ij_q = {in_item.ij_q[29:0], 1'b0};
      end
    end
    // One bit of each normal component over the finished root.
    if (STEP >= qfgf_pkg::NRM_FIRST && STEP < qfgf_pkg::CHAIN_LEN) begin
      if (nx_top >= 47'(in_item.root)) begin
        item_nxt.nx_rem = in_item.nx_rem - (47'(in_item.root) << NRM_SH);
        item_nxt.nx_q = {in_item.nx_q[14:0], 1'b1};
      end else begin
        item_nxt.nx_q = {in_item.nx_q[14:0], 1'b0};
      end
      if (ny_top >= 47'(in_item.root)) begin
        item_nxt.ny_rem = in_item.ny_rem - (47'(in_item.root) << NRM_SH);
        item_nxt.ny_q = {in_item.ny_q[14:0], 1'b1};
      end else begin
        item_nxt.ny_q = {in_item.ny_q[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (!stall) valid_r <= in_valid;
    if (!stall) item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item = item_r;

endmodule
